// ===== rtl/core/phpr_pkg.sv =====
// shared constants, types and rounding helper of the pinhole projection block
package phpr_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_LEN     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K      = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_QUAT = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X       = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y       = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z       = 8'd7;

	// register reset values
	localparam logic [15:0]        RST_FOCAL_LEN     = 16'd8000;
	localparam logic [15:0]        RST_CENTER_X      = 16'd6240;
	localparam logic [15:0]        RST_CENTER_Y      = 16'd4640;
	localparam logic signed [15:0] RST_RADIAL_K      = 16'sd0;
	localparam logic [63:0]        RST_ROTATION_QUAT = 64'h0000_0000_D333_2CCD;
	localparam logic signed [15:0] RST_SHIFT_X       = 16'sd0;
	localparam logic signed [15:0] RST_SHIFT_Y       = 16'sd1250;
	localparam logic [12:0]        RST_SHIFT_Z       = 13'd3500;

	// divider quotient widths
	localparam int DIV1_QW = 24;
	localparam int DIV2_QW = 25;

	// pipeline layout, stage index from 0
	localparam int ST_DIV1    = 4;
	localparam int ST_XC      = ST_DIV1 + DIV1_QW;
	localparam int ST_DIV2    = ST_XC + 1;
	localparam int ST_U       = ST_DIV2 + DIV2_QW;
	localparam int ST_FP      = ST_U + 7;
	localparam int NUM_STAGES = ST_FP + 1;

	// sideband carried beside the second divider
	typedef struct packed {
		logic       behind;
		logic [1:0] neg;
		logic [1:0] ovf;
	} side2_t;

	// shift right by s, rounding to nearest with ties away from zero
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] a,
		input int unsigned s);
		logic [63:0] m;
		logic [63:0] r;
		m = a[63] ? (64'd0 - $unsigned(a)) : $unsigned(a);
		r = (m + (64'd1 << (s - 1))) >> s;
		return a[63] ? $signed(64'd0 - r) : $signed(r);
	endfunction

endpackage

// ===== rtl/core/phpr_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module phpr_div #(
	parameter int NW = 61,
	parameter int DW = 34,
	parameter int QW = 24
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int CW  = (NW > DW + QW) ? NW : DW + QW;
	localparam int CW1 = CW + 1;

	logic [NW-1:0] rem_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [DW-1:0] den_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic [NW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic [CW:0]   shd;
		logic [CW:0]   diff;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		// trial subtract of the divisor aligned to this quotient bit
		assign shd  = CW1'(den_in) << (QW - 1 - j);
		assign diff = CW1'(rem_in) - shd;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= diff[CW] ? rem_in : diff[NW-1:0];
				quo_s[j] <= {quo_in[QW-2:0], ~diff[CW]};
				den_s[j] <= den_in;
			end
		end
	end

	assign quo = quo_s[QW-1];

endmodule

// ===== rtl/core/pinhole_projection_radial.sv =====
// pinhole camera projection with one-term radial distortion, top level
//
// channels: points come in on in_valid/in_ready with point_x/y/z in mm,
// results leave on out_valid/out_ready as image_x/image_y (pixels, 4 fraction
// bits, saturated) and behind_camera. one result per request, in order.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while no request is in flight.
// throughput: one request per cycle while in_ready is high; the pipeline
// carries one point per stage with no dependence between points.
// stages: 24 are the rotation divider (one quotient bit each) and 25 the
// perspective divider.
// stall: the output register is backed by a one-entry skid register; when
// the receiver stalls the pipeline moves once more into the skid entry and
// then in_ready drops until the skid entry moves into the output.
// reset: configuration registers take their reset values, all valid bits
// and the output/skid stage clear; payload registers are not reset.
module pinhole_projection_radial (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [phpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [phpr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [15:0]              point_x,
	input  logic signed [15:0]              point_y,
	input  logic signed [15:0]              point_z,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [15:0]              image_x,
	output logic signed [15:0]              image_y,
	output logic                            behind_camera
);

	import phpr_pkg::*;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [15:0]        focal_len_q;
	logic [15:0]        center_x_q;
	logic [15:0]        center_y_q;
	logic signed [15:0] radial_k_q;
	logic [63:0]        rotation_quat_q;
	logic signed [15:0] shift_x_q;
	logic signed [15:0] shift_y_q;
	logic [12:0]        shift_z_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_len_q     <= RST_FOCAL_LEN;
			center_x_q      <= RST_CENTER_X;
			center_y_q      <= RST_CENTER_Y;
			radial_k_q      <= RST_RADIAL_K;
			rotation_quat_q <= RST_ROTATION_QUAT;
			shift_x_q       <= RST_SHIFT_X;
			shift_y_q       <= RST_SHIFT_Y;
			shift_z_q       <= RST_SHIFT_Z;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FOCAL_LEN:     focal_len_q     <= cfg_data[15:0];
				REG_CENTER_X:      center_x_q      <= cfg_data[15:0];
				REG_CENTER_Y:      center_y_q      <= cfg_data[15:0];
				REG_RADIAL_K:      radial_k_q      <= cfg_data[15:0];
				REG_ROTATION_QUAT: rotation_quat_q <= cfg_data;
				REG_SHIFT_X:       shift_x_q       <= cfg_data[15:0];
				REG_SHIFT_Y:       shift_y_q       <= cfg_data[15:0];
				REG_SHIFT_Z:       shift_z_q       <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// pipeline control: every stage moves while the skid entry is free
	// ---------------------------------------------------------------
	logic                  run;
	logic [NUM_STAGES-1:0] vld_q;
	logic                  out_vld_q;
	logic                  skid_vld_q;

	assign run      = ~skid_vld_q;
	assign in_ready = run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (run) begin
			vld_q <= {vld_q[NUM_STAGES-2:0], in_valid};
		end
	end

	// ---------------------------------------------------------------
	// stage 1: quaternion part products, point capture
	// ---------------------------------------------------------------
	logic signed [15:0] qx, qy, qz, qw;
	logic signed [31:0] sq_xx_s1, sq_yy_s1, sq_zz_s1, sq_ww_s1;
	logic signed [31:0] pr_xy_s1, pr_xz_s1, pr_xw_s1, pr_yz_s1, pr_yw_s1, pr_zw_s1;
	logic signed [15:0] p_s1 [3];

	assign qx = rotation_quat_q[15:0];
	assign qy = rotation_quat_q[31:16];
	assign qz = rotation_quat_q[47:32];
	assign qw = rotation_quat_q[63:48];

	always_ff @(posedge clk) begin
		if (run) begin
			sq_xx_s1 <= qx * qx;
			sq_yy_s1 <= qy * qy;
			sq_zz_s1 <= qz * qz;
			sq_ww_s1 <= qw * qw;
			pr_xy_s1 <= qx * qy;
			pr_xz_s1 <= qx * qz;
			pr_xw_s1 <= qx * qw;
			pr_yz_s1 <= qy * qz;
			pr_yw_s1 <= qy * qw;
			pr_zw_s1 <= qz * qw;
			p_s1[0]  <= point_x;
			p_s1[1]  <= point_y;
			p_s1[2]  <= point_z;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: scaled rotation matrix M = n*R and its scale n
	// ---------------------------------------------------------------
	logic signed [33:0] exx, eyy, ezz, eww, exy, exz, exw, eyz, eyw, ezw;
	logic signed [33:0] nsum;
	logic signed [33:0] mm [3][3];
	logic [32:0]        nsel;
	logic signed [33:0] m_s2 [3][3];
	logic [32:0]        n_s2;
	logic signed [15:0] p_s2 [3];

	assign exx = 34'(sq_xx_s1);
	assign eyy = 34'(sq_yy_s1);
	assign ezz = 34'(sq_zz_s1);
	assign eww = 34'(sq_ww_s1);
	assign exy = 34'(pr_xy_s1);
	assign exz = 34'(pr_xz_s1);
	assign exw = 34'(pr_xw_s1);
	assign eyz = 34'(pr_yz_s1);
	assign eyw = 34'(pr_yw_s1);
	assign ezw = 34'(pr_zw_s1);

	always_comb begin
		nsum = exx + eyy + ezz + eww;
		if (nsum == '0) begin
			// all-zero quaternion: identity rotation, unit scale
			mm[0][0] = 34'sd1;
			mm[0][1] = '0;
			mm[0][2] = '0;
			mm[1][0] = '0;
			mm[1][1] = 34'sd1;
			mm[1][2] = '0;
			mm[2][0] = '0;
			mm[2][1] = '0;
			mm[2][2] = 34'sd1;
			nsel     = 33'd1;
		end else begin
			mm[0][0] = eww + exx - eyy - ezz;
			mm[1][1] = eww - exx + eyy - ezz;
			mm[2][2] = eww - exx - eyy + ezz;
			mm[0][1] = (exy - ezw) <<< 1;
			mm[1][0] = (exy + ezw) <<< 1;
			mm[0][2] = (exz + eyw) <<< 1;
			mm[2][0] = (exz - eyw) <<< 1;
			mm[1][2] = (eyz - exw) <<< 1;
			mm[2][1] = (eyz + exw) <<< 1;
			nsel     = nsum[32:0];
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			m_s2 <= mm;
			n_s2 <= nsel;
			p_s2 <= p_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: matrix-vector products
	// ---------------------------------------------------------------
	logic signed [49:0] mp_s3 [3][3];
	logic [32:0]        n_s3;

	always_ff @(posedge clk) begin
		if (run) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mp_s3[i][j] <= m_s2[i][j] * p_s2[j];
				end
			end
			n_s3 <= n_s2;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: row sums, operands of round(a*256/n)
	// numerator 2|a|*256 + n over divisor 2n gives the rounded quotient
	// ---------------------------------------------------------------
	logic signed [51:0] asum [3];
	logic [51:0]        amag [3];
	logic [60:0]        num1_s4 [3];
	logic [33:0]        den1_s4;
	logic [2:0]         neg1_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			asum[i] = 52'(mp_s3[i][0]) + 52'(mp_s3[i][1]) + 52'(mp_s3[i][2]);
			amag[i] = asum[i][51] ? (52'd0 - $unsigned(asum[i])) : $unsigned(asum[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			for (int i = 0; i < 3; i++) begin
				num1_s4[i] <= {amag[i], 9'b0} + 61'(n_s3);
				neg1_s4[i] <= asum[i][51];
			end
			den1_s4 <= {n_s3, 1'b0};
		end
	end

	// ---------------------------------------------------------------
	// stages 5..28: rotation divider, one per axis
	// ---------------------------------------------------------------
	logic [DIV1_QW-1:0] q1 [3];
	logic [2:0]         neg1_s [DIV1_QW];

	for (genvar i = 0; i < 3; i++) begin : g_div1
		phpr_div #(
			.NW(61),
			.DW(34),
			.QW(DIV1_QW)
		) u_div1 (
			.clk(clk),
			.en (run),
			.num(num1_s4[i]),
			.den(den1_s4),
			.quo(q1[i])
		);
	end

	always_ff @(posedge clk) begin
		if (run) begin
			neg1_s[0] <= neg1_s4;
			for (int k = 1; k < DIV1_QW; k++) begin
				neg1_s[k] <= neg1_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 29: camera coordinates (mm, 8 fraction bits), depth test and
	// operands of round(c*65536/zc) with an early overflow test for the
	// saturation at 256.0
	// ---------------------------------------------------------------
	logic signed [25:0] rq [3];
	logic signed [25:0] xc, yc, zc;
	logic [24:0]        cmag [2];
	logic [42:0]        num2 [2];
	logic [25:0]        den2;
	logic [1:0]         ovf2;
	logic [42:0]        num2_s29 [2];
	logic [25:0]        den2_s29;
	side2_t             side_s29;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rq[i] = neg1_s[DIV1_QW-1][i] ? -$signed({2'b00, q1[i]}) : $signed({2'b00, q1[i]});
		end
		xc = rq[0] + (26'(shift_x_q) <<< 8);
		yc = rq[1] + (26'(shift_y_q) <<< 8);
		zc = rq[2] + $signed({5'b0, shift_z_q, 8'b0});
		cmag[0] = xc[25] ? 25'($unsigned(-xc)) : 25'($unsigned(xc));
		cmag[1] = yc[25] ? 25'($unsigned(-yc)) : 25'($unsigned(yc));
		den2 = {zc[24:0], 1'b0};
		for (int i = 0; i < 2; i++) begin
			num2[i] = {1'b0, cmag[i], 17'b0} + {18'b0, zc[24:0]};
			ovf2[i] = {8'b0, num2[i]} >= {den2, 25'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			num2_s29        <= num2;
			den2_s29        <= den2;
			side_s29.behind <= zc[25] || (zc == '0);
			side_s29.neg    <= {yc[25], xc[25]};
			side_s29.ovf    <= ovf2;
		end
	end

	// ---------------------------------------------------------------
	// stages 30..54: perspective divider for u and v
	// ---------------------------------------------------------------
	logic [DIV2_QW-1:0] q2 [2];
	side2_t             side_s [DIV2_QW];

	for (genvar i = 0; i < 2; i++) begin : g_div2
		phpr_div #(
			.NW(43),
			.DW(26),
			.QW(DIV2_QW)
		) u_div2 (
			.clk(clk),
			.en (run),
			.num(num2_s29[i]),
			.den(den2_s29),
			.quo(q2[i])
		);
	end

	always_ff @(posedge clk) begin
		if (run) begin
			side_s[0] <= side_s29;
			for (int k = 1; k < DIV2_QW; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// stages 55..62: saturation of u/v, r^2, distortion factor, focal scale
	// ---------------------------------------------------------------
	localparam logic [DIV2_QW-1:0] NORM_LIMIT = 25'd16777216;

	logic [DIV2_QW-1:0] qf [2];
	logic signed [25:0] u_s55 [2];
	logic               behind_s55;
	logic signed [25:0] u_s56 [2];
	logic [49:0]        uu_s56 [2];
	logic               behind_s56;
	logic signed [25:0] u_s57 [2];
	logic [34:0]        r2_s57;
	logic               behind_s57;
	logic signed [25:0] u_s58 [2];
	logic signed [51:0] kr_s58;
	logic               behind_s58;
	logic signed [25:0] u_s59 [2];
	logic signed [35:0] f16_s59;
	logic               behind_s59;
	logic signed [61:0] uf_s60 [2];
	logic               behind_s60;
	logic signed [34:0] ud_s61 [2];
	logic               behind_s61;
	logic signed [51:0] fp_s62 [2];
	logic               behind_s62;

	logic [24:0]        umag [2];
	logic [50:0]        r2sum;
	logic signed [52:0] fsum;
	logic signed [63:0] f16w;
	logic signed [63:0] udw [2];
	logic signed [34:0] udc [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			qf[i] = (side_s[DIV2_QW-1].ovf[i] || (q2[i] > NORM_LIMIT)) ? NORM_LIMIT : q2[i];
			umag[i] = u_s55[i][25] ? 25'($unsigned(-u_s55[i])) : 25'($unsigned(u_s55[i]));
			udw[i] = rnd_shr(64'(uf_s60[i]), 16);
			// beyond 2^33 the image coordinate saturates for any nonzero focal length
			if (udw[i] > 64'sd8589934592) begin
				udc[i] = 35'sd8589934592;
			end else if (udw[i] < -64'sd8589934592) begin
				udc[i] = -35'sd8589934592;
			end else begin
				udc[i] = udw[i][34:0];
			end
		end
		r2sum = {1'b0, uu_s56[0]} + {1'b0, uu_s56[1]} + 51'd32768;
		fsum  = 53'(kr_s58) + 53'sd2147483648;
		f16w  = rnd_shr(64'(fsum), 15);
	end

	always_ff @(posedge clk) begin
		if (run) begin
			for (int i = 0; i < 2; i++) begin
				u_s55[i] <= side_s[DIV2_QW-1].neg[i] ? -$signed({1'b0, qf[i]})
					: $signed({1'b0, qf[i]});
				u_s56[i]  <= u_s55[i];
				uu_s56[i] <= umag[i] * umag[i];
				u_s57[i]  <= u_s56[i];
				u_s58[i]  <= u_s57[i];
				u_s59[i]  <= u_s58[i];
				uf_s60[i] <= u_s59[i] * f16_s59;
				ud_s61[i] <= udc[i];
				fp_s62[i] <= $signed({1'b0, focal_len_q}) * ud_s61[i];
			end
			behind_s55 <= side_s[DIV2_QW-1].behind;
			behind_s56 <= behind_s55;
			r2_s57     <= r2sum[50:16];
			behind_s57 <= behind_s56;
			kr_s58     <= radial_k_q * $signed({1'b0, r2_s57});
			behind_s58 <= behind_s57;
			f16_s59    <= f16w[35:0];
			behind_s59 <= behind_s58;
			behind_s60 <= behind_s59;
			behind_s61 <= behind_s60;
			behind_s62 <= behind_s61;
		end
	end

	// ---------------------------------------------------------------
	// final rounding, principal point, saturation; output and skid entry
	// ---------------------------------------------------------------
	logic signed [63:0] pix [2];
	logic signed [15:0] img_c [2];
	logic               iv;
	logic signed [15:0] img_x_q, img_y_q, skid_x_q, skid_y_q;
	logic               behind_q, skid_behind_q;

	always_comb begin
		pix[0] = rnd_shr(64'(fp_s62[0]), 16) + $signed({48'b0, center_x_q});
		pix[1] = rnd_shr(64'(fp_s62[1]), 16) + $signed({48'b0, center_y_q});
		for (int i = 0; i < 2; i++) begin
			if (behind_s62) begin
				img_c[i] = '0;
			end else if (pix[i] > 64'sd32767) begin
				img_c[i] = 16'sh7FFF;
			end else if (pix[i] < -64'sd32768) begin
				img_c[i] = 16'sh8000;
			end else begin
				img_c[i] = pix[i][15:0];
			end
		end
	end

	// a result leaves the last stage only while the pipeline moves
	assign iv = vld_q[NUM_STAGES-1] && run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= iv;
			end
		end else if (iv) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				img_x_q  <= skid_x_q;
				img_y_q  <= skid_y_q;
				behind_q <= skid_behind_q;
			end else if (iv) begin
				img_x_q  <= img_c[0];
				img_y_q  <= img_c[1];
				behind_q <= behind_s62;
			end
		end else if (iv) begin
			skid_x_q      <= img_c[0];
			skid_y_q      <= img_c[1];
			skid_behind_q <= behind_s62;
		end
	end

	assign out_valid     = out_vld_q;
	assign image_x       = img_x_q;
	assign image_y       = img_y_q;
	assign behind_camera = behind_q;

endmodule

// ===== rtl/core/phpr_checker.sv =====
// port-level checks of the pinhole projection block and their bind
module phpr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] image_x,
	input logic [15:0] image_y,
	input logic        behind_camera
);

	// a point at or behind the camera plane gives zero coordinates
	a_behind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && behind_camera |-> image_x == 16'd0 && image_y == 16'd0)
		else $error("behind_camera result with nonzero coordinates");

	// the skid entry can only be full while a result waits at the output
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(image_x) && $stable(image_y)
			&& $stable(behind_camera))
		else $error("stalled result changed");

endmodule

bind pinhole_projection_radial phpr_checker u_phpr_checker (.*);
